@@ rtl/positional_list_insert_delete_top_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the positional list
// Shared wrappers for the concurrent checks on the top level's ports.
// ----------------------------------------------------------------------------
`ifndef POSITIONAL_LIST_INSERT_DELETE_TOP_MACROS_SVH
`define POSITIONAL_LIST_INSERT_DELETE_TOP_MACROS_SVH

// Same-cycle implication, sampled on clk, ignored while arst_n is low.
`define PLID_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("positional list check failed");

// Next-cycle implication, sampled on clk, ignored while arst_n is low.
`define PLID_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("positional list check failed");

`endif

@@ rtl/plid_pkg.sv @@
// ----------------------------------------------------------------------------
// Positional list package
// Sizes, operation and status codes and the cell control word.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package plid_pkg;

	localparam int DEPTH   = 16;
	localparam int DATA_W  = 32;
	localparam int OP_W    = 2;
	localparam int POS_W   = 5;
	localparam int STAT_W  = 2;
	localparam int LEN_W   = $clog2(DEPTH + 1);
	localparam int IDX_W   = $clog2(DEPTH);
	localparam int CMP_W   = (LEN_W > POS_W) ? LEN_W : POS_W;

	localparam logic [OP_W-1:0] OP_INSERT  = 2'd0;
	localparam logic [OP_W-1:0] OP_DELETE  = 2'd1;
	localparam logic [OP_W-1:0] OP_DISPLAY = 2'd2;

	localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
	localparam logic [STAT_W-1:0] ST_INVALID = 2'd1;
	localparam logic [STAT_W-1:0] ST_EMPTY   = 2'd2;
	localparam logic [STAT_W-1:0] ST_FULL    = 2'd3;

	typedef enum logic [1:0] {
		CMD_HOLD,
		CMD_INS,
		CMD_DEL,
		CMD_ROT
	} plid_cmd_t;

	typedef struct packed {
		plid_cmd_t               kind;
		logic [CMP_W-1:0]        pos;
		logic [CMP_W-1:0]        tail;
		logic signed [DATA_W-1:0] data;
	} plid_ctl_t;

endpackage

@@ rtl/plid_cell.sv @@
// ----------------------------------------------------------------------------
// Positional list cell
// Holds one element and moves it to or from its neighbors on command.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module plid_cell
	import plid_pkg::*;
(
	input  logic                     clk,
	input  logic [IDX_W-1:0]         idx,
	input  plid_ctl_t                ctl,
	input  logic signed [DATA_W-1:0] left_data,
	input  logic signed [DATA_W-1:0] right_data,
	input  logic signed [DATA_W-1:0] head_data,
	output logic signed [DATA_W-1:0] cell_data,
	output logic signed [DATA_W-1:0] sel_data
);

	logic signed [DATA_W-1:0] data_q;
	logic [CMP_W-1:0]         idx_x;

	assign idx_x     = CMP_W'(idx);
	assign cell_data = data_q;
	assign sel_data  = (idx_x == ctl.pos) ? data_q : '0;

	always_ff @(posedge clk) begin
		case (ctl.kind)
			CMD_INS: begin
				if (idx_x == ctl.pos) begin
					data_q <= ctl.data;
				end else if (idx_x > ctl.pos) begin
					data_q <= left_data;
				end
			end
			CMD_DEL: begin
				if (idx_x >= ctl.pos) begin
					data_q <= right_data;
				end
			end
			CMD_ROT: begin
				if (idx_x == ctl.tail) begin
					data_q <= head_data;
				end else begin
					data_q <= right_data;
				end
			end
			default: begin
				data_q <= data_q;
			end
		endcase
	end

endmodule

@@ rtl/positional_list_insert_delete_top.sv @@
// Insert, delete and bad or empty requests give one word in the cycle after acceptance.
// Display rotates the cell row for one word per held element, one a cycle unless stalled.
// A new request is taken once all words of the previous one are out, so an insert or
// delete sustains one request per cycle unless stalled, and a display holds the input.
// Reset clears the count and the control state; cell contents stay undefined.
// ----------------------------------------------------------------------------
// Positional list top level
// Ordered list of signed words held in a row of shifting cells.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module positional_list_insert_delete_top
	import plid_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     req_valid,
	output logic                     req_stall,
	input  logic [OP_W-1:0]          operation,
	input  logic [POS_W-1:0]         position,
	input  logic signed [DATA_W-1:0] value,
	output logic                     rsp_valid,
	input  logic                     rsp_stall,
	output logic [STAT_W-1:0]        status,
	output logic signed [DATA_W-1:0] element,
	output logic                     last
);

	localparam logic STATE_IDLE    = 1'b0;
	localparam logic STATE_DISPLAY = 1'b1;

	logic                     state_q;
	logic                     state_d;
	logic [LEN_W-1:0]         length_q;
	logic [LEN_W-1:0]         length_d;
	logic [IDX_W-1:0]         cnt_q;
	logic [IDX_W-1:0]         cnt_d;
	logic                     rsp_valid_q;
	logic [STAT_W-1:0]        status_q;
	logic signed [DATA_W-1:0] element_q;
	logic                     last_q;

	logic                     accept;
	logic                     out_free;
	logic                     emit;
	logic [STAT_W-1:0]        emit_status;
	logic signed [DATA_W-1:0] emit_element;
	logic                     emit_last;
	logic [CMP_W-1:0]         len_x;
	logic [CMP_W-1:0]         pos_x;
	plid_ctl_t                ctl;

	logic signed [DATA_W-1:0] cell_data [DEPTH];
	logic signed [DATA_W-1:0] sel_data  [DEPTH];
	logic signed [DATA_W-1:0] sel_any;

	assign out_free  = !rsp_valid_q || !rsp_stall;
	assign req_stall = (state_q != STATE_IDLE) || !out_free;
	assign accept    = req_valid && !req_stall;
	assign len_x     = CMP_W'(length_q);
	assign pos_x     = CMP_W'(position);

	genvar gi;
	generate
		for (gi = 0; gi < DEPTH; gi++) begin : g_cell
			logic signed [DATA_W-1:0] left_w;
			logic signed [DATA_W-1:0] right_w;
			if (gi == 0) begin : g_first
				assign left_w = '0;
			end else begin : g_inner_l
				assign left_w = cell_data[gi-1];
			end
			if (gi == DEPTH - 1) begin : g_end
				assign right_w = '0;
			end else begin : g_inner_r
				assign right_w = cell_data[gi+1];
			end
			plid_cell u_cell (
				.clk        (clk),
				.idx        (IDX_W'(gi)),
				.ctl        (ctl),
				.left_data  (left_w),
				.right_data (right_w),
				.head_data  (cell_data[0]),
				.cell_data  (cell_data[gi]),
				.sel_data   (sel_data[gi])
			);
		end
	endgenerate

	always_comb begin
		sel_any = '0;
		for (int i = 0; i < DEPTH; i++) begin
			sel_any = sel_any | sel_data[i];
		end
	end

	always_comb begin
		ctl.kind     = CMD_HOLD;
		ctl.pos      = pos_x;
		ctl.tail     = len_x - CMP_W'(1);
		ctl.data     = value;
		state_d      = state_q;
		length_d     = length_q;
		cnt_d        = cnt_q;
		emit         = 1'b0;
		emit_status  = ST_OK;
		emit_element = '0;
		emit_last    = 1'b1;
		if (state_q == STATE_DISPLAY) begin
			if (out_free) begin
				ctl.kind     = CMD_ROT;
				emit         = 1'b1;
				emit_element = cell_data[0];
				emit_last    = (CMP_W'(cnt_q) == ctl.tail);
				cnt_d        = cnt_q + IDX_W'(1);
				if (emit_last) begin
					state_d = STATE_IDLE;
				end
			end
		end else if (accept) begin
			emit = 1'b1;
			unique case (operation)
				OP_INSERT: begin
					if (length_q == '0) begin
						ctl.kind = CMD_INS;
						ctl.pos  = '0;
						length_d = length_q + LEN_W'(1);
					end else if (len_x == CMP_W'(DEPTH)) begin
						emit_status = ST_FULL;
					end else if (pos_x > len_x) begin
						emit_status = ST_INVALID;
					end else begin
						ctl.kind = CMD_INS;
						length_d = length_q + LEN_W'(1);
					end
				end
				OP_DELETE: begin
					if (length_q == '0) begin
						emit_status = ST_EMPTY;
					end else if (pos_x >= len_x) begin
						emit_status = ST_INVALID;
					end else begin
						ctl.kind     = CMD_DEL;
						emit_element = sel_any;
						length_d     = length_q - LEN_W'(1);
					end
				end
				OP_DISPLAY: begin
					if (length_q == '0) begin
						emit_status = ST_EMPTY;
					end else begin
						emit    = 1'b0;
						state_d = STATE_DISPLAY;
						cnt_d   = '0;
					end
				end
				default: begin
					emit_status = ST_INVALID;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= STATE_IDLE;
			length_q    <= '0;
			cnt_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			length_q <= length_d;
			cnt_q    <= cnt_d;
			if (emit) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			status_q  <= emit_status;
			element_q <= emit_element;
			last_q    <= emit_last;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign status    = status_q;
	assign element   = element_q;
	assign last      = last_q;

endmodule

@@ rtl/plid_checker.sv @@
// ----------------------------------------------------------------------------
// Positional list port checker
// Watches the top level's ports and flags words that break the list rules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "positional_list_insert_delete_top_macros.svh"

module plid_checker
	import plid_pkg::*;
(
	input logic                     clk,
	input logic                     arst_n,
	input logic                     req_stall,
	input logic                     rsp_valid,
	input logic                     rsp_stall,
	input logic [STAT_W-1:0]        status,
	input logic signed [DATA_W-1:0] element,
	input logic                     last
);

	`PLID_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(status) && $stable(element) && $stable(last))
	`PLID_ASSERT_NOW(a_err_last, rsp_valid && (status != ST_OK), last)
	`PLID_ASSERT_NOW(a_err_zero, rsp_valid && (status != ST_OK), element == '0)
	`PLID_ASSERT_NOW(a_busy_display, rsp_valid && !last, req_stall)

endmodule

bind positional_list_insert_delete_top plid_checker u_plid_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_stall (req_stall),
	.rsp_valid (rsp_valid),
	.rsp_stall (rsp_stall),
	.status    (status),
	.element   (element),
	.last      (last)
);

@@ verif/tb_top.sv @@
// ----------------------------------------------------------------------------
// Positional list testbench
// Sends insert, delete, display and undefined requests to the list and checks
// every returned word against a list kept in the testbench, in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
	import plid_pkg::*;

	localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

	typedef struct {
		logic [STAT_W-1:0]        status;
		logic signed [DATA_W-1:0] element;
		logic                     last;
	} list_word_t;

	logic                     clk = 1'b0;
	logic                     arst_n = 1'b0;
	logic                     req_valid = 1'b0;
	logic                     req_stall;
	logic [OP_W-1:0]          operation = OP_INSERT;
	logic [POS_W-1:0]         position = '0;
	logic signed [DATA_W-1:0] value = '0;
	logic                     rsp_valid;
	logic                     rsp_stall = 1'b0;
	logic [STAT_W-1:0]        status;
	logic signed [DATA_W-1:0] element;
	logic                     last;

	logic signed [DATA_W-1:0] list_cells [DEPTH];
	int                       list_len = 0;
	list_word_t               pending_words [$];
	int                       mismatch_count = 0;
	int                       send_idle_pct = 31;
	int                       recv_idle_pct = 56;
	int                       hold_request = 0;
	int                       hold_left = 0;

	positional_list_insert_delete_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.operation (operation),
		.position  (position),
		.value     (value),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.status    (status),
		.element   (element),
		.last      (last)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	function automatic void apply_list_op(input logic [OP_W-1:0] op,
			input logic [POS_W-1:0] pos, input logic signed [DATA_W-1:0] val);
		list_word_t w;
		int         p;
		int         i;
		p = int'(pos);
		w.status = ST_OK;
		w.element = '0;
		w.last = 1'b1;
		case (op)
			OP_INSERT: begin
				if (list_len == 0) begin
					list_cells[0] = val;
					list_len = 1;
				end else if (list_len >= DEPTH) begin
					w.status = ST_FULL;
				end else if (p > list_len) begin
					w.status = ST_INVALID;
				end else begin
					for (i = list_len; i > p; i--)
						list_cells[i] = list_cells[i-1];
					list_cells[p] = val;
					list_len++;
				end
				pending_words.push_back(w);
			end
			OP_DELETE: begin
				if (list_len == 0) begin
					w.status = ST_EMPTY;
				end else if (p >= list_len) begin
					w.status = ST_INVALID;
				end else begin
					w.element = list_cells[p];
					for (i = p; i + 1 < list_len; i++)
						list_cells[i] = list_cells[i+1];
					list_len--;
				end
				pending_words.push_back(w);
			end
			OP_DISPLAY: begin
				if (list_len == 0) begin
					w.status = ST_EMPTY;
					pending_words.push_back(w);
				end else begin
					for (i = 0; i < list_len; i++) begin
						w.element = list_cells[i];
						w.last = (i == list_len - 1);
						pending_words.push_back(w);
					end
				end
			end
			default: begin
				w.status = ST_INVALID;
				pending_words.push_back(w);
			end
		endcase
	endfunction

	task automatic send_word(input logic [OP_W-1:0] op, input logic [POS_W-1:0] pos,
			input logic signed [DATA_W-1:0] val);
		bit taken;
		if ($urandom_range(99) < send_idle_pct) begin
			req_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
		end
		req_valid <= 1'b1;
		operation <= op;
		position <= pos;
		value <= val;
		do begin
			@(negedge clk);
			taken = !req_stall;
			@(posedge clk);
		end while (!taken);
		apply_list_op(op, pos, val);
	endtask

	// Mostly well-formed requests; the fill flag tilts the mix toward inserts.
	task automatic send_random_word(input bit fill);
		int               roll;
		logic [OP_W-1:0]  op;
		logic [POS_W-1:0] pos;
		roll = $urandom_range(99);
		pos = POS_W'($urandom_range(31));
		if (roll < 6) begin
			op = OP_UNUSED;
		end else if (roll < 14) begin
			op = $urandom_range(1) ? OP_INSERT : OP_DELETE;
		end else if (roll < 26) begin
			op = OP_DISPLAY;
		end else if (roll < (fill ? 80 : 46)) begin
			op = OP_INSERT;
			pos = POS_W'($urandom_range(list_len));
		end else begin
			op = OP_DELETE;
			pos = (list_len > 0) ? POS_W'($urandom_range(list_len - 1)) : '0;
		end
		send_word(op, pos, $urandom);
	endtask

	always @(posedge clk) begin
		if (hold_request > 0) begin
			hold_left = hold_request;
			hold_request = 0;
		end
		if (hold_left > 0) begin
			rsp_stall <= 1'b1;
			hold_left--;
		end else begin
			rsp_stall <= ($urandom_range(99) < recv_idle_pct);
		end
	end

	always @(negedge clk) begin : check_words
		list_word_t want;
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (pending_words.size() == 0) begin
				$display("%0t: unexpected word, status %0d element %0d last %0d",
					$time, status, element, last);
				mismatch_count++;
			end else begin
				want = pending_words.pop_front();
				if (status !== want.status) begin
					$display("%0t: status mismatch, expected %0d, actual %0d",
						$time, want.status, status);
					mismatch_count++;
				end
				if (element !== want.element) begin
					$display("%0t: element mismatch, expected %0d, actual %0d",
						$time, want.element, element);
					mismatch_count++;
				end
				if (last !== want.last) begin
					$display("%0t: last mismatch, expected %0d, actual %0d",
						$time, want.last, last);
					mismatch_count++;
				end
			end
		end
	end

	task automatic test_empty_list();
		send_word(OP_DISPLAY, 5'd0, 32'sd0);
		send_word(OP_DELETE, 5'd0, 32'sd0);
	endtask

	task automatic test_insert_cases();
		send_word(OP_INSERT, 5'd31, 32'sh8000_0000);
		send_word(OP_INSERT, 5'd0, 32'sh7fff_ffff);
		send_word(OP_INSERT, 5'd2, -32'sd1);
		send_word(OP_INSERT, 5'd1, 32'sd0);
		send_word(OP_INSERT, 5'd5, 32'sh5555_5555);
	endtask

	task automatic test_delete_cases();
		send_word(OP_DELETE, 5'd4, 32'sd0);
		send_word(OP_DELETE, 5'd31, 32'sd0);
		send_word(OP_DELETE, 5'd1, 32'sd0);
	endtask

	task automatic test_unused_op();
		send_word(OP_UNUSED, 5'd31, -32'sd1);
	endtask

	task automatic test_full_list();
		while (list_len < DEPTH)
			send_word(OP_INSERT, POS_W'($urandom_range(list_len)), $urandom);
		send_word(OP_INSERT, 5'd3, 32'sd1);
		send_word(OP_INSERT, 5'd31, 32'sd2);
		send_word(OP_DISPLAY, 5'd0, 32'sd0);
	endtask

	task automatic test_backpressure();
		int i;
		send_idle_pct = 0;
		hold_request = 60;
		for (i = 0; i < 20; i++)
			send_random_word(i < 10);
	endtask

	task automatic test_random_traffic();
		int step;
		int i;
		for (step = 0; step < 3; step++) begin
			send_idle_pct = (step == 0) ? 31 : (step == 1) ? 56 : 0;
			recv_idle_pct = (step == 0) ? 56 : (step == 1) ? 31 : 0;
			for (i = 0; i < 145; i++)
				send_random_word(((i / 40) % 2) == 0);
		end
	endtask

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_empty_list();
		test_insert_cases();
		test_delete_cases();
		test_unused_op();
		test_full_list();
		test_backpressure();
		test_random_traffic();
		req_valid <= 1'b0;
		while (pending_words.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

	initial begin
		#5_000_000;
		$display("%0t: timeout with %0d words outstanding", $time, pending_words.size());
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

@@ files.f @@
+incdir+rtl
rtl/plid_pkg.sv
rtl/plid_cell.sv
rtl/positional_list_insert_delete_top.sv
rtl/plid_checker.sv
verif/tb_top.sv
